// ===== rtl/rc_touch_key_scanner_assert.svh =====
// Assertion macros used by the touch key scanner top level.
`ifndef RC_TOUCH_KEY_SCANNER_ASSERT_SVH
`define RC_TOUCH_KEY_SCANNER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define RCTS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch key scanner check failed");
// Next-cycle implication.
`define RCTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch key scanner check failed");
`else
`define RCTS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RCTS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/rcts_pkg.sv =====
// Shared types and constants of the RC touch key scanner.
`timescale 1ns / 1ps
`default_nettype none
package rcts_pkg;

  localparam int NUM_KEYS_DEF    = 4;
  localparam int MAX_SAMPLES_DEF = 512;
  localparam int BURSTS_DEF      = 5;
  localparam int PRESS_VOTES     = 3;

  localparam int THRESH_W   = 9;
  localparam int HOLDOFF_W  = 16;
  localparam int HIST_W     = 8;
  localparam int KEY_SEL_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THRESH_W-1:0]  CHARGE_TH_RESET    = 9'd4;
  localparam logic [THRESH_W-1:0]  DISCHARGE_TH_RESET = 9'd8;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET      = 16'd43;

  typedef enum logic [1:0] {
    VERDICT_RELEASED    = 2'd0,
    VERDICT_TOUCHED     = 2'd1,
    VERDICT_UNDECIDABLE = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARGE_TH       = 2'd0,
    REG_DISCHARGE_TH    = 2'd1,
    REG_RELEASE_HOLDOFF = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [THRESH_W-1:0]  charge_th;
    logic [THRESH_W-1:0]  discharge_th;
    logic [HOLDOFF_W-1:0] holdoff;
  } cfg_t;

  // Outcome of the burst sequencer for the request being processed.
  typedef struct packed {
    logic finish;  // last burst of the current key ended
    logic press;   // enough touched votes
    logic none;    // no touched vote at all
  } scan_event_t;

endpackage
`default_nettype wire

// ===== rtl/rcts_if.sv =====
// Handshake channel interfaces of the RC touch key scanner.
`timescale 1ns / 1ps
`default_nettype none
interface rcts_in_if;
  logic valid;
  logic ready;
  logic sense_level;
  logic ms_tick;
  modport source (output valid, sense_level, ms_tick, input ready);
  modport sink (input valid, sense_level, ms_tick, output ready);
endinterface

interface rcts_out_if;
  import rcts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 drive_level;
  logic [KEY_SEL_W-1:0] key_select;
  logic                 status_valid;
  logic [1:0]           verdict;
  logic [HIST_W-1:0]    history;
  modport source (output valid, drive_level, key_select, status_valid, verdict, history,
                  input ready);
  modport sink (input valid, drive_level, key_select, status_valid, verdict, history,
                output ready);
endinterface

interface rcts_cfg_if;
  import rcts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rc_touch_key_scanner.sv =====
// RC touch key scanner top level: input and result registers around the scan logic.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_touch_key_scanner_assert.svh"
// The scanner takes one sense sample per request on the sample channel and returns
// exactly one result per request: the drive level and key to use for the next sample,
// and, when a key has just finished its bursts, its verdict and 8-bit history. A new
// request is accepted every clock cycle while the result channel is not stalled; each
// request goes through an input register and a result register. Sustained rate is one
// request per cycle when the result channel is not stalled, set by the combinational
// update of the burst sequencer and key state between those registers.
// Configuration writes on the cfg channel are always accepted and then registered.
module rc_touch_key_scanner #(
  parameter int NUM_KEYS    = rcts_pkg::NUM_KEYS_DEF,
  parameter int MAX_SAMPLES = rcts_pkg::MAX_SAMPLES_DEF,
  parameter int BURSTS      = rcts_pkg::BURSTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rcts_in_if.sink     sample,
  rcts_out_if.source  result,
  rcts_cfg_if.sink    cfg
);
  import rcts_pkg::*;

  localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cfg_t        regs;
  scan_event_t evt;
  verdict_t    verdict;
  logic [HIST_W-1:0] hist;
  logic [KEY_W-1:0]  key_cur;
  logic [KEY_W-1:0]  key_upd;
  logic              discharge_upd;

  logic in_valid_q;
  logic sense_q;
  logic tick_q;
  logic out_valid_q;
  logic advance;

  logic                 drive_q;
  logic [KEY_SEL_W-1:0] key_sel_q;
  logic                 status_q;
  logic [1:0]           verdict_q;
  logic [HIST_W-1:0]    hist_q;

  // A request moves from the input register to the result register when the
  // result register is empty or being drained this cycle.
  assign advance      = in_valid_q && (!out_valid_q || result.ready);
  assign sample.ready = !in_valid_q || advance;

  rcts_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rcts_burst_ctrl #(
    .NUM_KEYS    (NUM_KEYS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .BURSTS      (BURSTS)
  ) u_burst (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .sense         (sense_q),
    .regs          (regs),
    .evt           (evt),
    .key_cur       (key_cur),
    .key_upd       (key_upd),
    .discharge_upd (discharge_upd)
  );

  rcts_key_bank #(
    .NUM_KEYS (NUM_KEYS)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .tick    (tick_q),
    .key     (key_cur),
    .evt     (evt),
    .holdoff (regs.holdoff),
    .verdict (verdict),
    .hist    (hist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample.valid && sample.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      sense_q <= sample.sense_level;
      tick_q  <= sample.ms_tick;
    end
    if (advance) begin
      drive_q   <= !discharge_upd;
      key_sel_q <= KEY_SEL_W'(key_upd);
      status_q  <= evt.finish;
      verdict_q <= evt.finish ? verdict : VERDICT_RELEASED;
      hist_q    <= evt.finish ? hist : '0;
    end
  end

  assign result.valid        = out_valid_q;
  assign result.drive_level  = drive_q;
  assign result.key_select   = key_sel_q;
  assign result.status_valid = status_q;
  assign result.verdict      = verdict_q;
  assign result.history      = hist_q;

  `RCTS_ASSERT_IMPL(a_idle_result_clear, clk, rst, result.valid && !result.status_valid, result.verdict == VERDICT_RELEASED && result.history == '0)
  `RCTS_ASSERT_IMPL(a_touch_sets_newest, clk, rst, result.valid && result.status_valid && result.verdict == VERDICT_TOUCHED, result.history[0])
  `RCTS_ASSERT_NEXT(a_stalled_request_kept, clk, rst, in_valid_q && !advance, in_valid_q)

endmodule
`default_nettype wire

// ===== rtl/rcts_cfg_regs.sv =====
// Configuration register file: thresholds and release hold-off.
`timescale 1ns / 1ps
`default_nettype none
module rcts_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  rcts_cfg_if.sink      cfg,
  output rcts_pkg::cfg_t regs
);
  import rcts_pkg::*;

  cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign regs      = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.charge_th    <= CHARGE_TH_RESET;
      cfg_q.discharge_th <= DISCHARGE_TH_RESET;
      cfg_q.holdoff      <= HOLDOFF_RESET;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_CHARGE_TH:       cfg_q.charge_th    <= cfg.data[THRESH_W-1:0];
        REG_DISCHARGE_TH:    cfg_q.discharge_th <= cfg.data[THRESH_W-1:0];
        REG_RELEASE_HOLDOFF: cfg_q.holdoff      <= cfg.data[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcts_burst_ctrl.sv =====
// Burst sequencer: charge/discharge timing, voting and key rotation.
`timescale 1ns / 1ps
`default_nettype none
module rcts_burst_ctrl #(
  parameter int NUM_KEYS    = rcts_pkg::NUM_KEYS_DEF,
  parameter int MAX_SAMPLES = rcts_pkg::MAX_SAMPLES_DEF,
  parameter int BURSTS      = rcts_pkg::BURSTS_DEF,
  localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  sense,
  input  rcts_pkg::cfg_t        regs,
  output rcts_pkg::scan_event_t evt,
  output logic [KEY_W-1:0]      key_cur,
  output logic [KEY_W-1:0]      key_upd,
  output logic                  discharge_upd
);
  import rcts_pkg::*;

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int BURST_W = $clog2(BURSTS + 1);
  localparam int VOTE_MAX = (BURSTS > PRESS_VOTES) ? BURSTS : PRESS_VOTES;
  localparam int VOTE_W  = $clog2(VOTE_MAX + 1);
  localparam int CMP_W   = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;

  logic [KEY_W-1:0]   scan_key, scan_key_next;
  logic [BURST_W-1:0] burst_index, burst_index_next;
  logic               discharge_phase, discharge_phase_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  logic [CNT_W-1:0]   charge_delay, charge_delay_next;
  logic [VOTE_W-1:0]  vote_count, vote_count_next;

  logic [CNT_W-1:0]  cnt_inc;
  logic              cap;
  logic              dis_done;
  logic [CNT_W-1:0]  dis_delay;
  logic              vote;
  logic [VOTE_W-1:0] vote_total;
  logic              last_burst;

  assign cnt_inc = sample_count + CNT_W'(1);
  // A phase that reaches the sample cap ends with a delay equal to the cap.
  assign cap        = (cnt_inc == CNT_W'(MAX_SAMPLES));
  assign dis_done   = !sense || cap;
  assign dis_delay  = sense ? cnt_inc : sample_count;
  assign vote       = (CMP_W'(charge_delay) > CMP_W'(regs.charge_th)) &&
                      (CMP_W'(dis_delay) > CMP_W'(regs.discharge_th)) &&
                      (charge_delay != CNT_W'(MAX_SAMPLES)) &&
                      (dis_delay != CNT_W'(MAX_SAMPLES));
  assign vote_total = vote_count + VOTE_W'(vote);
  assign last_burst = (burst_index == BURST_W'(BURSTS - 1));

  assign evt.finish    = discharge_phase && dis_done && last_burst;
  assign evt.press     = (vote_total >= VOTE_W'(PRESS_VOTES));
  assign evt.none      = (vote_total == '0);
  assign key_cur       = scan_key;
  assign key_upd       = scan_key_next;
  assign discharge_upd = discharge_phase_next;

  always_comb begin
    scan_key_next        = scan_key;
    burst_index_next     = burst_index;
    discharge_phase_next = discharge_phase;
    sample_count_next    = sample_count;
    charge_delay_next    = charge_delay;
    vote_count_next      = vote_count;
    if (step) begin
      if (!discharge_phase) begin
        if (sense || cap) begin
          charge_delay_next    = sense ? sample_count : cnt_inc;
          discharge_phase_next = 1'b1;
          sample_count_next    = '0;
        end else begin
          sample_count_next = cnt_inc;
        end
      end else if (dis_done) begin
        discharge_phase_next = 1'b0;
        sample_count_next    = '0;
        if (last_burst) begin
          burst_index_next  = '0;
          vote_count_next   = '0;
          charge_delay_next = '0;
          scan_key_next     = (scan_key == KEY_W'(NUM_KEYS - 1)) ? '0
                                                                 : scan_key + KEY_W'(1);
        end else begin
          burst_index_next = burst_index + BURST_W'(1);
          vote_count_next  = vote_total;
        end
      end else begin
        sample_count_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_key        <= '0;
      burst_index     <= '0;
      discharge_phase <= 1'b0;
      sample_count    <= '0;
      charge_delay    <= '0;
      vote_count      <= '0;
    end else begin
      scan_key        <= scan_key_next;
      burst_index     <= burst_index_next;
      discharge_phase <= discharge_phase_next;
      sample_count    <= sample_count_next;
      charge_delay    <= charge_delay_next;
      vote_count      <= vote_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcts_key_bank.sv =====
// Per-key status history and press timers, with the end-of-key verdict.
`timescale 1ns / 1ps
`default_nettype none
module rcts_key_bank #(
  parameter int NUM_KEYS = rcts_pkg::NUM_KEYS_DEF,
  localparam int KEY_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         tick,
  input  logic [KEY_W-1:0]             key,
  input  rcts_pkg::scan_event_t        evt,
  input  logic [rcts_pkg::HOLDOFF_W-1:0] holdoff,
  output rcts_pkg::verdict_t           verdict,
  output logic [rcts_pkg::HIST_W-1:0]  hist
);
  import rcts_pkg::*;

  logic [HIST_W-1:0]    key_history [NUM_KEYS];
  logic [HIST_W-1:0]    key_history_next [NUM_KEYS];
  logic [HOLDOFF_W-1:0] since_press_ms [NUM_KEYS];
  logic [HOLDOFF_W-1:0] since_press_ms_next [NUM_KEYS];

  always_comb begin
    key_history_next = key_history;
    for (int k = 0; k < NUM_KEYS; k++) begin
      since_press_ms_next[k] = since_press_ms[k];
      if (step && tick && (since_press_ms[k] != '1)) begin
        since_press_ms_next[k] = since_press_ms[k] + HOLDOFF_W'(1);
      end
    end

    if (evt.press) begin
      verdict = VERDICT_TOUCHED;
    end else if (evt.none) begin
      verdict = VERDICT_RELEASED;
    end else begin
      verdict = VERDICT_UNDECIDABLE;
    end

    // The tick above is applied first, so the release check sees the new count.
    if (step && evt.finish) begin
      if (evt.press) begin
        key_history_next[key]    = {key_history[key][HIST_W-2:0], 1'b1};
        since_press_ms_next[key] = '0;
      end else if (evt.none && (since_press_ms_next[key] > holdoff)) begin
        key_history_next[key] = {key_history[key][HIST_W-2:0], 1'b0};
      end
    end
    hist = key_history_next[key];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_history[k]    <= '0;
        since_press_ms[k] <= '0;
      end
    end else begin
      key_history    <= key_history_next;
      since_press_ms <= since_press_ms_next;
    end
  end

endmodule
`default_nettype wire

// ===== dv/rc_touch_key_scanner_tb.sv =====
// Self-checking testbench for the RC touch key scanner: burst stimulus, scan predictor, result checks.
`timescale 1ns / 1ps
module rc_touch_key_scanner_tb;
  import rcts_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic                 drive;
    logic [KEY_SEL_W-1:0] key;
    logic                 status;
    logic [1:0]           verdict;
    logic [HIST_W-1:0]    hist;
  } scan_out_t;

  typedef enum int {AIM_PRESS, AIM_RELEASE, AIM_MIXED} key_aim_t;

  logic clk;
  logic rst;

  rcts_in_if  sample_if ();
  rcts_out_if result_if ();
  rcts_cfg_if cfg_if ();

  rc_touch_key_scanner u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // Predictor state: per-key history and press timers, plus the burst sequencer.
  logic [HIST_W-1:0]    touch_history [NUM_KEYS_DEF];
  logic [HOLDOFF_W-1:0] ms_since_press [NUM_KEYS_DEF];
  logic [KEY_SEL_W-1:0] scan_pos;
  int unsigned          burst_no;
  bit                   discharging;
  int unsigned          phase_count;
  int unsigned          charge_len;
  int unsigned          touch_votes;
  logic [THRESH_W-1:0]  charge_limit;
  logic [THRESH_W-1:0]  discharge_limit;
  logic [HOLDOFF_W-1:0] release_wait;

  scan_out_t   pending_scans [$];
  int          mismatches;
  int          cycle_count;
  int unsigned items_sent;
  int          tick_pct;
  bit          sender_idle;
  bit          recv_idle;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void reset_scan_model();
    for (int k = 0; k < NUM_KEYS_DEF; k++) begin
      touch_history[k] = '0;
      ms_since_press[k] = '0;
    end
    scan_pos = '0;
    burst_no = 0;
    discharging = 1'b0;
    phase_count = 0;
    charge_len = 0;
    touch_votes = 0;
    charge_limit = CHARGE_TH_RESET;
    discharge_limit = DISCHARGE_TH_RESET;
    release_wait = HOLDOFF_RESET;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CHARGE_TH: begin
        charge_limit = val[THRESH_W-1:0];
      end
      REG_DISCHARGE_TH: begin
        discharge_limit = val[THRESH_W-1:0];
      end
      REG_RELEASE_HOLDOFF: begin
        release_wait = val[HOLDOFF_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Advances the predictor by one sense sample and returns the result it calls for.
  function automatic scan_out_t scan_step(bit sense, bit tick);
    scan_out_t   r;
    bit          finished;
    int unsigned dis_len;
    r = '0;
    finished = 1'b0;
    dis_len = 0;
    if (tick) begin
      for (int k = 0; k < NUM_KEYS_DEF; k++) begin
        if (ms_since_press[k] != '1) ms_since_press[k] = ms_since_press[k] + 1'b1;
      end
    end
    if (!discharging) begin
      if (sense) begin
        charge_len = phase_count;
        discharging = 1'b1;
        phase_count = 0;
      end else begin
        phase_count++;
        if (phase_count >= MAX_SAMPLES_DEF) begin
          charge_len = MAX_SAMPLES_DEF;
          discharging = 1'b1;
          phase_count = 0;
        end
      end
    end else begin
      if (!sense) begin
        dis_len = phase_count;
        finished = 1'b1;
      end else begin
        phase_count++;
        if (phase_count >= MAX_SAMPLES_DEF) begin
          dis_len = MAX_SAMPLES_DEF;
          finished = 1'b1;
        end
      end
      if (finished) begin
        discharging = 1'b0;
        phase_count = 0;
        if (charge_len > charge_limit && dis_len > discharge_limit &&
            charge_len < MAX_SAMPLES_DEF && dis_len < MAX_SAMPLES_DEF) begin
          touch_votes++;
        end
        burst_no++;
        if (burst_no >= BURSTS_DEF) begin
          if (touch_votes >= PRESS_VOTES) begin
            r.verdict = VERDICT_TOUCHED;
            touch_history[scan_pos] = {touch_history[scan_pos][HIST_W-2:0], 1'b1};
            ms_since_press[scan_pos] = '0;
          end else if (touch_votes == 0) begin
            r.verdict = VERDICT_RELEASED;
            if (ms_since_press[scan_pos] > release_wait) begin
              touch_history[scan_pos] = {touch_history[scan_pos][HIST_W-2:0], 1'b0};
            end
          end else begin
            r.verdict = VERDICT_UNDECIDABLE;
          end
          r.status = 1'b1;
          r.hist = touch_history[scan_pos];
          burst_no = 0;
          touch_votes = 0;
          charge_len = 0;
          scan_pos = scan_pos + 1'b1;
        end
      end
    end
    r.drive = !discharging;
    r.key = scan_pos;
    return r;
  endfunction

  function automatic string describe(scan_out_t r);
    return $sformatf("drive=%0b key=%0d status=%0b verdict=%0d history=%02h",
                     r.drive, r.key, r.status, r.verdict, r.hist);
  endfunction

  function automatic void check_result();
    scan_out_t got;
    scan_out_t want;
    got.drive = result_if.drive_level;
    got.key = result_if.key_select;
    got.status = result_if.status_valid;
    got.verdict = result_if.verdict;
    got.hist = result_if.history;
    if (pending_scans.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no request waiting: %s", describe(got));
      return;
    end
    want = pending_scans.pop_front();
    if (got.drive !== want.drive || got.key !== want.key || got.status !== want.status ||
        got.verdict !== want.verdict || got.hist !== want.hist) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch: expected %s, got %s", describe(want), describe(got));
      end
    end
  endfunction

  // Result side: random stalls before each result while recv_idle is set, then check it on acceptance.
  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
      while (!(result_if.valid && result_if.ready)) @(posedge clk);
      check_result();
    end
  end

  function automatic bit draw_tick();
    return $urandom_range(0, 99) < tick_pct;
  endfunction

  // Valid stays high from one request to the next when no gap is drawn.
  task automatic send_sample(bit sense, bit tick);
    int gap;
    sample_if.valid <= 1'b1;
    sample_if.sense_level <= sense;
    sample_if.ms_tick <= tick;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    pending_scans.push_back(scan_step(sense, tick));
    items_sent++;
    gap = sender_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One burst from the start of a charge phase; lengths of MAX_SAMPLES or more hit the cap.
  task automatic send_burst(int unsigned ch, int unsigned dis);
    for (int unsigned i = 0; i < ch && i < MAX_SAMPLES_DEF; i++) send_sample(1'b0, draw_tick());
    if (ch < MAX_SAMPLES_DEF) send_sample(1'b1, draw_tick());
    for (int unsigned i = 0; i < dis && i < MAX_SAMPLES_DEF; i++) send_sample(1'b1, draw_tick());
    if (dis < MAX_SAMPLES_DEF) send_sample(1'b0, draw_tick());
  endtask

  // Finishes the current key with bursts that cannot vote, leaving the next key at burst 0.
  task automatic align_to_key();
    if (discharging) begin
      send_sample(1'b0, draw_tick());
    end else if (phase_count != 0) begin
      send_sample(1'b1, draw_tick());
      send_sample(1'b0, draw_tick());
    end
    while (burst_no != 0) send_burst(0, 0);
  endtask

  // The sender stops until every request in flight has its result back.
  task automatic drain();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (pending_scans.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  // Threshold writes carry random upper bits, which the block must drop.
  task automatic write_regs(logic [THRESH_W-1:0] ct, logic [THRESH_W-1:0] dt,
                            logic [HOLDOFF_W-1:0] ho);
    write_reg(REG_CHARGE_TH, {7'($urandom_range(0, 127)), ct});
    write_reg(REG_DISCHARGE_TH, {7'($urandom_range(0, 127)), dt});
    write_reg(REG_RELEASE_HOLDOFF, ho);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic scan_one_key(key_aim_t aim);
    int unsigned ch;
    int unsigned dis;
    bit          vote;
    for (int b = 0; b < BURSTS_DEF; b++) begin
      case (aim)
        AIM_PRESS: vote = ($urandom_range(0, 3) != 0);
        AIM_MIXED: vote = $urandom_range(0, 1);
        default:   vote = 1'b0;
      endcase
      if (vote) begin
        ch = charge_limit + 1 + $urandom_range(0, 2);
        dis = discharge_limit + 1 + $urandom_range(0, 2);
      end else if ($urandom_range(0, 1)) begin
        ch = $urandom_range(0, charge_limit);
        dis = $urandom_range(0, discharge_limit + 3);
      end else begin
        ch = $urandom_range(0, charge_limit + 3);
        dis = $urandom_range(0, discharge_limit);
      end
      // Keep bursts short under high thresholds; such keys simply never vote.
      if (ch > 12) ch = $urandom_range(0, 12);
      if (dis > 12) dis = $urandom_range(0, 12);
      send_burst(ch, dis);
    end
  endtask

  task automatic run_random_keys(int unsigned n_items);
    int unsigned stop;
    int          noise;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 15) begin
        noise = $urandom_range(1, 8);
        repeat (noise) send_sample(1'($urandom_range(0, 1)), draw_tick());
        if ($urandom_range(0, 1)) align_to_key();
      end
      scan_one_key(key_aim_t'($urandom_range(0, 2)));
    end
  endtask

  task automatic test_reset_defaults();
    tick_pct = 30;
    run_random_keys(50);
  endtask

  task automatic test_directed();
    tick_pct = 50;
    align_to_key();
    drain();
    write_regs('0, '0, '0);
    repeat (3) send_burst(1, 1);
    repeat (2) send_burst(0, 0);
    send_burst(1, 1);
    repeat (4) send_burst(0, 0);
  endtask

  task automatic test_count_cap();
    tick_pct = 10;
    align_to_key();
    drain();
    write_regs('0, '0, 16'd20);
    // A capped charge phase must not vote, so two good bursts leave the key undecidable.
    send_burst(MAX_SAMPLES_DEF, 3);
    repeat (2) send_burst(1, 1);
    repeat (2) send_burst(0, 0);
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      sender_idle = 1'b1;
      recv_idle = 1'b1;
      case (ph)
        0: begin
          tick_pct = 50;
          write_regs('0, '0, '0);
        end
        1: begin
          tick_pct = 40;
          write_regs(9'($urandom_range(1, 10)), 9'($urandom_range(1, 10)),
                     16'($urandom_range(0, 20)));
        end
        2: begin
          tick_pct = 30;
          write_regs('1, '1, '1);
        end
        3: begin
          tick_pct = 70;
          sender_idle = 1'b0;
          recv_idle = 1'b0;
          write_regs(9'($urandom_range(0, 6)), 9'($urandom_range(0, 6)), 16'd3);
        end
        4: begin
          tick_pct = 50;
          write_regs('0, '1, 16'($urandom_range(0, 10)));
        end
        5: begin
          tick_pct = 20;
          write_regs('1, '0, '0);
        end
        default: begin
          tick_pct = 90;
          write_regs(9'($urandom_range(2, 8)), 9'($urandom_range(2, 8)), HOLDOFF_RESET);
        end
      endcase
      run_random_keys(30);
    end
    sender_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Press one key, then scan released keys back to back while ticks pass a short hold-off.
  task automatic test_holdoff_release();
    sender_idle = 1'b0;
    recv_idle = 1'b0;
    tick_pct = 0;
    align_to_key();
    drain();
    write_regs('0, '0, 16'd6);
    repeat (3) send_burst(1, 1);
    repeat (2) send_burst(0, 0);
    tick_pct = 25;
    repeat (NUM_KEYS_DEF * BURSTS_DEF * 2) send_burst(0, 0);
    drain();
    sender_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    sample_if.valid <= 1'b0;
    sample_if.sense_level <= 1'b0;
    sample_if.ms_tick <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_CHARGE_TH;
    cfg_if.data <= '0;
    mismatches = 0;
    cycle_count = 0;
    items_sent = 0;
    tick_pct = 30;
    sender_idle = 1'b1;
    recv_idle = 1'b1;
    reset_scan_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_count_cap();
    test_random_mix();
    test_holdoff_release();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_scans.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
